@@ src/lrc_pkg.sv @@
// ----------------------------------------------------------------------------
// lrc_pkg: shared types and constants of the LED request controller
// Request and confirm item layouts, request kinds, modes and register indexes.
// ----------------------------------------------------------------------------
package lrc_pkg;

  localparam int unsigned KindW  = 3;
  localparam int unsigned LevelW = 10;
  localparam int unsigned SeqW   = 16;
  localparam int unsigned PerW   = 16;
  localparam int unsigned PulseW = 17;
  localparam int unsigned ProdW  = 26;   // (period+1) * level, up to 65536 * 1000
  localparam int unsigned CfgIdxW  = 8;
  localparam int unsigned CfgDataW = 16;

  localparam logic [LevelW-1:0] LevelFull = LevelW'(1000);

  // floor(x / 1000) = (x * Recip) >> RecipShift, exact for x < 2^26
  localparam int unsigned RecipShift = 36;
  localparam int unsigned RecipW     = 27;
  localparam logic [RecipW-1:0] Recip = RecipW'(68719477);
  localparam int unsigned QuotW = ProdW + RecipW;

  localparam logic [KindW-1:0] KindStart = 3'd0;
  localparam logic [KindW-1:0] KindStop  = 3'd1;
  localparam logic [KindW-1:0] KindOn    = 3'd2;
  localparam logic [KindW-1:0] KindOff   = 3'd3;
  localparam logic [KindW-1:0] KindLevel = 3'd4;

  localparam logic [CfgIdxW-1:0] RegTimerPeriod  = 8'd0;
  localparam logic [CfgIdxW-1:0] RegActiveHigh   = 8'd1;
  localparam logic [CfgIdxW-1:0] RegDefaultLevel = 8'd2;
  localparam logic [CfgIdxW-1:0] RegPwmPresent   = 8'd3;

  typedef enum logic [1:0] {
    ModeStopped = 2'd0,
    ModeOff     = 2'd1,
    ModeOn      = 2'd2
  } mode_e;

  typedef struct packed {
    logic [KindW-1:0]  kind;
    logic [LevelW-1:0] level_permil;
    logic [SeqW-1:0]   sequence_req;
  } req_t;

  typedef struct packed {
    logic [KindW-1:0]  confirm_kind;
    logic              status;
    logic [SeqW-1:0]   confirm_sequence;
    logic [1:0]        mode;
    logic              drive_update;
    logic              drive_enabled;
    logic [PulseW-1:0] pulse_count;
    logic              pin_level;
  } cfm_t;

endpackage

@@ src/led_request_controller_core.sv @@
// ----------------------------------------------------------------------------
// led_request_controller_core: LED request controller
// Stages: input register, state update with duty multiply into the middle
// register, then divide-by-1000 reciprocal multiply into the result register.
// Throughput: one request per cycle; each pipeline stage advances whenever the
// stage after it is empty or moving. Reset clears mode, level and drive state
// and loads the register defaults; the block takes items right after reset.
// ----------------------------------------------------------------------------
module led_request_controller_core (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  lrc_pkg::req_t                   in_data_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output lrc_pkg::cfm_t                   out_data_o,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [lrc_pkg::CfgIdxW-1:0]     cfg_index_i,
  input  logic [lrc_pkg::CfgDataW-1:0]    cfg_data_i
);
  import lrc_pkg::*;

  // configuration
  logic [PerW-1:0]   timer_period_q;
  logic              active_high_q;
  logic [LevelW-1:0] default_level_q;
  logic              pwm_present_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timer_period_q  <= PerW'(999);
      active_high_q   <= 1'b1;
      default_level_q <= LevelW'(100);
      pwm_present_q   <= 1'b1;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        RegTimerPeriod:  timer_period_q  <= cfg_data_i[PerW-1:0];
        RegActiveHigh:   active_high_q   <= cfg_data_i[0];
        RegDefaultLevel: default_level_q <= cfg_data_i[LevelW-1:0];
        RegPwmPresent:   pwm_present_q   <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // pipeline handshake
  logic in_v_q, mid_v_q, out_v_q;
  logic out_rdy, mid_rdy, in_rdy;

  assign out_rdy    = !out_v_q || !out_stall_i;
  assign mid_rdy    = !mid_v_q || out_rdy;
  assign in_rdy     = !in_v_q || mid_rdy;
  assign in_stall_o = !in_rdy;

  logic fire_in, fire_mid, fire_out;
  assign fire_in  = in_valid_i && in_rdy;
  assign fire_mid = in_v_q && mid_rdy;
  assign fire_out = mid_v_q && out_rdy;

  // input register
  req_t req_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_v_q <= 1'b0;
    end else if (in_rdy) begin
      in_v_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire_in) begin
      req_q <= in_data_i;
    end
  end

  // state update
  mode_e             mode_q, mode_d;
  logic [LevelW-1:0] level_q, level_d;
  logic [ProdW-1:0]  prod_q, prod_d;     // duty product; pulse is prod / 1000
  logic              pin_q, pin_d;

  logic [LevelW-1:0] req_lvl, def_lvl, prog_lvl, eff_lvl;
  logic [PulseW-1:0] period_p1;
  logic              prog, err, upd, lit;

  assign req_lvl   = (req_q.level_permil > LevelFull) ? LevelFull : req_q.level_permil;
  assign def_lvl   = (default_level_q > LevelFull) ? LevelFull : default_level_q;
  assign period_p1 = {1'b0, timer_period_q} + PulseW'(1);

  always_comb begin
    mode_d   = mode_q;
    level_d  = level_q;
    prog     = 1'b0;
    prog_lvl = '0;
    err      = 1'b0;
    upd      = 1'b0;
    case (mode_q)
      ModeStopped: begin
        if (req_q.kind == KindStart) begin
          level_d = def_lvl;
          mode_d  = ModeOff;
          prog    = 1'b1;
          upd     = 1'b1;
        end else if (req_q.kind != KindStop) begin
          err = 1'b1;
        end
      end
      default: begin
        case (req_q.kind)
          KindStop: mode_d = ModeStopped;
          KindOn: begin
            if (mode_q == ModeOff) begin
              mode_d   = ModeOn;
              prog     = 1'b1;
              prog_lvl = level_q;
              upd      = 1'b1;
            end
          end
          KindOff: begin
            if (mode_q == ModeOn) begin
              mode_d = ModeOff;
              prog   = 1'b1;
              upd    = 1'b1;
            end
          end
          KindLevel: begin
            level_d = req_lvl;
            if (mode_q == ModeOn && level_q != req_lvl) begin
              prog     = 1'b1;
              prog_lvl = req_lvl;
              upd      = 1'b1;
            end
          end
          default: err = 1'b1;
        endcase
      end
    endcase
  end

  assign eff_lvl = active_high_q ? prog_lvl : (LevelFull - prog_lvl);
  assign lit     = (prog_lvl != '0);

  always_comb begin
    prod_d = prod_q;
    pin_d  = pin_q;
    if (prog) begin
      if (pwm_present_q) begin
        prod_d = ProdW'(period_p1) * ProdW'(eff_lvl);
      end else begin
        pin_d = active_high_q ? lit : !lit;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= ModeStopped;
      level_q <= '0;
      prod_q  <= '0;
      pin_q   <= 1'b0;
    end else if (fire_mid) begin
      mode_q  <= mode_d;
      level_q <= level_d;
      prod_q  <= prod_d;
      pin_q   <= pin_d;
    end
  end

  // middle register: confirm without the final divide
  cfm_t             mid_q;
  logic [ProdW-1:0] mid_prod_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mid_v_q <= 1'b0;
    end else if (mid_rdy) begin
      mid_v_q <= in_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire_mid) begin
      mid_q.confirm_kind     <= req_q.kind;
      mid_q.status           <= err;
      mid_q.confirm_sequence <= req_q.sequence_req;
      mid_q.mode             <= mode_d;
      mid_q.drive_update     <= upd;
      mid_q.drive_enabled    <= (mode_d != ModeStopped);
      mid_q.pulse_count      <= '0;
      mid_q.pin_level        <= pwm_present_q ? 1'b0 : pin_d;
      mid_prod_q             <= pwm_present_q ? prod_d : '0;
    end
  end

  // divide by 1000 through the reciprocal
  logic [QuotW-1:0]  quot_full;
  logic [PulseW-1:0] pulse;

  assign quot_full = QuotW'(mid_prod_q) * QuotW'(Recip);
  assign pulse     = quot_full[RecipShift +: PulseW];

  // result register
  cfm_t out_q, out_d;

  always_comb begin
    out_d             = mid_q;
    out_d.pulse_count = pulse;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (out_rdy) begin
      out_v_q <= mid_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire_out) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_v_q;
  assign out_data_o  = out_q;

endmodule

@@ tb/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for led_request_controller_core
// Drives LED requests with random sender gaps and receiver stalls, tracks the
// mode, level and drive state alongside the block, and compares every confirm
// field by field. The register settings change between batches while idle.
// ----------------------------------------------------------------------------
module tb_top;
  import lrc_pkg::*;

  localparam logic [KindW-1:0] KindBadLo  = 3'd5;
  localparam logic [KindW-1:0] KindBadMid = 3'd6;
  localparam logic [KindW-1:0] KindBadHi  = 3'd7;
  localparam int unsigned      Batches    = 8;
  localparam int unsigned      BatchItems = 100;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                in_valid = 1'b0;
  logic                in_stall;
  req_t                in_data = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  cfm_t                out_data;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [CfgIdxW-1:0]  cfg_index = '0;
  logic [CfgDataW-1:0] cfg_data = '0;

  // shadow registers and LED state
  logic [PerW-1:0]   cfg_period = 16'd999;
  logic              cfg_active_high = 1'b1;
  logic [LevelW-1:0] cfg_default_level = 10'd100;
  logic              cfg_pwm = 1'b1;
  mode_e             led_mode = ModeStopped;
  logic [LevelW-1:0] led_level = '0;
  logic [PulseW-1:0] duty_count = '0;
  logic              pin_out = 1'b0;

  req_t pending_reqs[$];
  cfm_t expected_cfms[$];
  bit   req_taken = 1'b0;
  int   fail_count = 0;
  int unsigned in_idle_pct = 9;
  int unsigned out_stall_pct = 65;

  led_request_controller_core dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  function automatic logic [LevelW-1:0] clamp_level(input logic [LevelW-1:0] lvl);
    return (lvl > LevelFull) ? LevelFull : lvl;
  endfunction

  // reprogram PWM compare or plain pin for a (clamped) level
  function automatic void drive_level(input logic [LevelW-1:0] lvl);
    logic [LevelW-1:0] eff;
    longint unsigned   prod;
    if (!cfg_pwm) begin
      pin_out = cfg_active_high ? (lvl != '0) : (lvl == '0);
    end else begin
      eff = cfg_active_high ? lvl : LevelFull - lvl;
      prod = (64'(cfg_period) + 64'd1) * 64'(eff) / 64'(LevelFull);
      duty_count = prod[PulseW-1:0];
    end
  endfunction

  function automatic cfm_t predict_confirm(input req_t rq);
    cfm_t              c;
    logic [LevelW-1:0] lv;
    logic              rejected;
    logic              reprog;
    lv = clamp_level(rq.level_permil);
    rejected = 1'b0;
    reprog = 1'b0;
    if (led_mode == ModeStopped) begin
      if (rq.kind == KindStart) begin
        led_level = clamp_level(cfg_default_level);
        led_mode = ModeOff;
        drive_level('0);
        reprog = 1'b1;
      end else if (rq.kind != KindStop) begin
        rejected = 1'b1;
      end
    end else begin
      case (rq.kind)
        KindStop: led_mode = ModeStopped;
        KindOn: if (led_mode == ModeOff) begin
          led_mode = ModeOn;
          drive_level(led_level);
          reprog = 1'b1;
        end
        KindOff: if (led_mode == ModeOn) begin
          led_mode = ModeOff;
          drive_level('0);
          reprog = 1'b1;
        end
        KindLevel: if (led_mode == ModeOn) begin
          // only a real change touches the drive while lit
          if (led_level != lv) begin
            led_level = lv;
            drive_level(lv);
            reprog = 1'b1;
          end
        end else begin
          led_level = lv;
        end
        default: rejected = 1'b1;
      endcase
    end
    c.confirm_kind     = rq.kind;
    c.status           = rejected;
    c.confirm_sequence = rq.sequence_req;
    c.mode             = led_mode;
    c.drive_update     = reprog;
    c.drive_enabled    = (led_mode != ModeStopped);
    c.pulse_count      = cfg_pwm ? duty_count : '0;
    c.pin_level        = cfg_pwm ? 1'b0 : pin_out;
    return c;
  endfunction

  function automatic req_t random_req();
    req_t        r;
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 14) r.kind = KindStart;
    else if (pick < 24) r.kind = KindStop;
    else if (pick < 44) r.kind = KindOn;
    else if (pick < 64) r.kind = KindOff;
    else if (pick < 95) r.kind = KindLevel;
    else r.kind = KindW'($urandom_range(KindBadHi, KindBadLo));
    case ($urandom_range(9))
      0: r.level_permil = '0;
      1: r.level_permil = LevelFull;
      2: r.level_permil = LevelW'($urandom_range(1023, 1001));
      3, 4: r.level_permil = $urandom_range(1) ? 10'd250 : 10'd500;
      default: r.level_permil = LevelW'($urandom_range(1023));
    endcase
    r.sequence_req = SeqW'($urandom_range(65535));
    return r;
  endfunction

  task automatic add_req(input logic [KindW-1:0] k, input logic [LevelW-1:0] lvl,
                         input logic [SeqW-1:0] seq);
    req_t r;
    r.kind = k;
    r.level_permil = lvl;
    r.sequence_req = seq;
    pending_reqs.push_back(r);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      RegTimerPeriod:  cfg_period = val[PerW-1:0];
      RegActiveHigh:   cfg_active_high = val[0];
      RegDefaultLevel: cfg_default_level = val[LevelW-1:0];
      RegPwmPresent:   cfg_pwm = val[0];
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // sender holds off until every confirm is back, then lets the pipe settle
  task automatic wait_drained();
    while (pending_reqs.size() != 0 || expected_cfms.size() != 0) @(posedge clk);
    repeat (5) @(posedge clk);
  endtask

  task automatic compare_field(input string field, input int unsigned want,
                               input int unsigned got);
    if (want != got) begin
      $display("%0t: confirm %s mismatch, expected %0h, actual %0h", $time, field, want, got);
      fail_count++;
    end
  endtask

  // request acceptance: predict the confirm in accept order
  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall) begin
      expected_cfms.push_back(predict_confirm(in_data));
      void'(pending_reqs.pop_front());
      req_taken = 1'b1;
    end
  end

  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      out_stall <= 1'b0;
    end else begin
      if (!in_valid || req_taken) begin
        req_taken = 1'b0;
        if (pending_reqs.size() != 0 && $urandom_range(99) >= in_idle_pct) begin
          in_valid <= 1'b1;
          in_data  <= pending_reqs[0];
        end else begin
          in_valid <= 1'b0;
        end
      end
      out_stall <= ($urandom_range(99) < out_stall_pct);
    end
  end

  always @(posedge clk) begin
    cfm_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_cfms.size() == 0) begin
        $display("%0t: unexpected confirm, expected none, actual %h", $time, out_data);
        fail_count++;
      end else begin
        want = expected_cfms.pop_front();
        compare_field("kind", want.confirm_kind, out_data.confirm_kind);
        compare_field("status", want.status, out_data.status);
        compare_field("sequence", want.confirm_sequence, out_data.confirm_sequence);
        compare_field("mode", want.mode, out_data.mode);
        compare_field("drive_update", want.drive_update, out_data.drive_update);
        compare_field("drive_enabled", want.drive_enabled, out_data.drive_enabled);
        compare_field("pulse_count", want.pulse_count, out_data.pulse_count);
        compare_field("pin_level", want.pin_level, out_data.pin_level);
      end
    end
  end

  initial begin
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;

    // wrong-state requests and unknown kinds while stopped, then start, on, level, off and stop
    add_req(KindOn, 10'd0, 16'h0000);
    add_req(KindOff, 10'd0, 16'hffff);
    add_req(KindLevel, 10'd1023, 16'h1234);
    add_req(KindBadLo, 10'd1023, 16'h8001);
    add_req(KindBadHi, 10'd0, 16'h7ffe);
    add_req(KindStop, 10'd0, 16'h0001);
    add_req(KindStart, 10'd0, 16'h0002);
    add_req(KindStart, 10'd0, 16'h0003);
    add_req(KindLevel, 10'd1023, 16'h0004);  // clamped, stored while off
    add_req(KindOn, 10'd0, 16'h0005);
    add_req(KindLevel, 10'd1000, 16'h0006);  // same level: no reprogram
    add_req(KindLevel, 10'd0, 16'h0007);
    add_req(KindLevel, 10'd1, 16'h0008);
    add_req(KindOn, 10'd0, 16'h0009);
    add_req(KindBadMid, 10'd512, 16'h000a);
    add_req(KindOff, 10'd0, 16'h000b);
    add_req(KindOff, 10'd0, 16'h000c);
    add_req(KindLevel, 10'd512, 16'h000d);
    add_req(KindOn, 10'd0, 16'h000e);
    add_req(KindStop, 10'd0, 16'h000f);
    add_req(KindStop, 10'd0, 16'h0010);
    add_req(KindStart, 10'd0, 16'h0011);
    add_req(KindOn, 10'd0, 16'h0012);
    wait_drained();

    for (int b = 0; b < Batches; b++) begin
      if (b == 3) begin
        in_idle_pct = 65;
        out_stall_pct = 9;
      end
      if (b == 6) begin
        in_idle_pct = 0;
        out_stall_pct = 0;
      end
      case (b)
        1: begin
          write_reg(RegTimerPeriod, 16'd0);
          write_reg(RegActiveHigh, 16'd0);
          write_reg(RegDefaultLevel, 16'd1000);
        end
        2: begin
          write_reg(RegTimerPeriod, 16'hffff);
          write_reg(RegActiveHigh, 16'd1);
          write_reg(RegDefaultLevel, 16'd0);
        end
        3: begin
          write_reg(RegPwmPresent, 16'd0);
          write_reg(RegTimerPeriod, 16'd500);
          write_reg(RegDefaultLevel, 16'd1023);
        end
        4: begin
          write_reg(RegActiveHigh, 16'd0);
          write_reg(RegDefaultLevel, 16'd0);
        end
        5: begin
          write_reg(RegPwmPresent, 16'd1);
          write_reg(RegTimerPeriod, CfgDataW'($urandom_range(65535)));
          write_reg(RegActiveHigh, CfgDataW'($urandom_range(1)));
          write_reg(RegDefaultLevel, CfgDataW'($urandom_range(1023)));
        end
        6: begin
          write_reg(RegTimerPeriod, 16'hffff);
          write_reg(RegActiveHigh, 16'd0);
          write_reg(RegDefaultLevel, 16'd1001);
        end
        7: begin
          write_reg(RegTimerPeriod, CfgDataW'($urandom_range(65535)));
          write_reg(RegActiveHigh, CfgDataW'($urandom_range(1)));
          write_reg(RegDefaultLevel, CfgDataW'($urandom_range(1023)));
          write_reg(RegPwmPresent, CfgDataW'($urandom_range(1)));
        end
        default: ;
      endcase
      repeat (BatchItems) pending_reqs.push_back(random_req());
      wait_drained();
    end

    repeat (10) @(posedge clk);
    if (fail_count == 0) begin
      $display("led_request_controller_core test passed");
    end else begin
      $display("led_request_controller_core test failed");
    end
    $finish;
  end

  initial begin
    #4000000;
    $display("%0t: timeout, %0d requests and %0d confirms outstanding", $time,
             pending_reqs.size(), expected_cfms.size());
    $display("led_request_controller_core test failed");
    $finish;
  end

endmodule
